FILE: src/apf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Allpass filter package
// Shared widths, register indexes and the sequencer state type for the
// multichannel first-order allpass lowpass/highpass filter.
// ----------------------------------------------------------------------------
package apf_pkg;

   localparam int SAMPLE_W = 16;
   localparam int COEF_W = 16;
   localparam int COUNT_W = 4;
   localparam int CHANNEL_W = 3;
   localparam int DELAY_W = 18;
   localparam int AP_W = 19;
   localparam int PROD_W = COEF_W + AP_W;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 16;
   localparam int MAX_CHANNELS_DEFAULT = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_COEFFICIENT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HIGH_PASS_MODE = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHANNEL_COUNT = 2'd2;

   typedef enum logic [1:0] {
      S_IDLE,
      S_MUL1,
      S_MUL2,
      S_DONE
   } apf_state_type;

endpackage

FILE: src/apf_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sample request channel
// Valid/ready channel that carries one input sample per request.
// ----------------------------------------------------------------------------
interface apf_req_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [apf_pkg::SAMPLE_W-1:0]   sample;

   modport source (output valid, output sample, input ready);
   modport sink (input valid, input sample, output ready);
endinterface

FILE: src/apf_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Filtered sample response channel
// Valid/ready channel that carries one filtered sample and its channel.
// ----------------------------------------------------------------------------
interface apf_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [apf_pkg::SAMPLE_W-1:0]   filtered;
   logic [apf_pkg::CHANNEL_W-1:0]         channel;

   modport source (output valid, output filtered, output channel, input ready);
   modport sink (input valid, input filtered, input channel, output ready);
endinterface

FILE: src/apf_csr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel that carries a register index and write data.
// ----------------------------------------------------------------------------
interface apf_csr_if;
   logic                                  valid;
   logic                                  ready;
   logic [apf_pkg::CSR_INDEX_W-1:0]       index;
   logic [apf_pkg::CSR_DATA_W-1:0]        data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

FILE: src/allpass_lowpass_highpass_filter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multichannel first-order allpass lowpass/highpass filter
// An accepted request passes through S_MUL1, S_MUL2 and S_DONE; the result is
// registered as it leaves S_DONE. A new request is taken only in S_IDLE, after
// the two passes through the single shared multiplier and the delay store access
// in the sequencer. A stalled result holds the sequencer in its last step until it is taken.
// Reset clears the settings, the state, the channel counter and every delay valid flag.
// ----------------------------------------------------------------------------
module allpass_lowpass_highpass_filter_core #(
   parameter int MAX_CHANNELS = apf_pkg::MAX_CHANNELS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   apf_req_if.sink    req_chan,
   apf_rsp_if.source  rsp_chan,
   apf_csr_if.sink    csr_chan
);
   import apf_pkg::*;

   localparam int IW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int MW = $clog2(MAX_CHANNELS + 1);
   localparam int CW = (MW > COUNT_W) ? MW : COUNT_W;
   localparam logic signed [20:0] DELAY_HI = 21'sd131071;
   localparam logic signed [20:0] DELAY_LO = -21'sd131072;
   localparam logic signed [17:0] OUT_HI = 18'sd32767;
   localparam logic signed [17:0] OUT_LO = -18'sd32768;

   apf_state_type state_ff;
   apf_state_type state_in;

   logic signed [COEF_W-1:0]   coef_ff;
   logic                       hpm_ff;
   logic [COUNT_W-1:0]         count_ff;

   logic [IW-1:0]              next_ch_ff;
   logic [IW-1:0]              next_ch_in;
   logic [IW-1:0]              ch_sel;
   logic [IW-1:0]              ch_ff;
   logic [CW-1:0]              count_ext;
   logic [CW-1:0]              count_eff;

   logic signed [SAMPLE_W-1:0] x_ff;
   logic signed [DELAY_W-1:0]  d_ff;
   logic                       d_valid_ff;
   logic signed [DELAY_W-1:0]  d_eff;
   logic signed [AP_W-1:0]     ap_ff;
   logic signed [AP_W-1:0]     ap_in;

   logic signed [DELAY_W-1:0]  delay_mem [MAX_CHANNELS];
   logic [MAX_CHANNELS-1:0]    valid_ff;

   logic                       mul_en;
   logic signed [AP_W-1:0]     mul_b;
   logic signed [PROD_W-1:0]   prod;
   logic signed [PROD_W-1:0]   rnd1;
   logic signed [PROD_W-1:0]   rnd2;
   logic signed [19:0]         r2;
   logic signed [20:0]         nd;
   logic signed [DELAY_W-1:0]  nd_sat;
   logic signed [19:0]         x16;
   logic signed [19:0]         y_rnd;
   logic signed [17:0]         y_q;
   logic signed [SAMPLE_W-1:0] y_sat;

   logic                       req_accept;
   logic                       out_free;
   logic                       finish;

   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_filtered_ff;
   logic [CHANNEL_W-1:0]       rsp_channel_ff;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= '0;
         hpm_ff <= 1'b0;
         count_ff <= COUNT_W'(1);
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_COEFFICIENT: begin
               coef_ff <= csr_chan.data[COEF_W-1:0];
            end
            CSR_HIGH_PASS_MODE: begin
               hpm_ff <= csr_chan.data[0];
            end
            CSR_CHANNEL_COUNT: begin
               count_ff <= csr_chan.data[COUNT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      count_ext = CW'(count_ff);
      if (count_ext == '0) begin
         count_eff = CW'(1);
      end else if (count_ext > CW'(MAX_CHANNELS)) begin
         count_eff = CW'(MAX_CHANNELS);
      end else begin
         count_eff = count_ext;
      end
      ch_sel = (CW'(next_ch_ff) >= count_eff) ? '0 : next_ch_ff;
      next_ch_in = ((CW'(ch_sel) + CW'(1)) >= count_eff) ? '0 : ch_sel + IW'(1);
   end

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_accept = req_chan.valid && req_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign finish = (state_ff == S_DONE) && out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      mul_en = 1'b0;
      mul_b = {{(AP_W - SAMPLE_W){x_ff[SAMPLE_W-1]}}, x_ff};
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               state_in = S_MUL1;
            end
         end
         S_MUL1: begin
            mul_en = 1'b1;
            state_in = S_MUL2;
         end
         S_MUL2: begin
            mul_en = 1'b1;
            mul_b = ap_in;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   apf_mul u_mul (
      .clock   (clock),
      .enable  (mul_en),
      .coef    (coef_ff),
      .operand (mul_b),
      .product (prod)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         next_ch_ff <= '0;
      end else if (req_accept) begin
         next_ch_ff <= next_ch_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         x_ff <= req_chan.sample;
         ch_ff <= ch_sel;
         d_ff <= delay_mem[ch_sel];
         d_valid_ff <= valid_ff[ch_sel];
      end
   end

   always_comb begin
      d_eff = d_valid_ff ? d_ff : '0;
      rnd1 = prod + PROD_W'(8192);
      ap_in = rnd1[32:14] + {d_eff[DELAY_W-1], d_eff};
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_MUL2) begin
         ap_ff <= ap_in;
      end
   end

   always_comb begin
      x16 = {{3{x_ff[SAMPLE_W-1]}}, x_ff, 1'b0};
      rnd2 = prod + PROD_W'(16384);
      r2 = rnd2[34:15];
      nd = {x16[19], x16} - {r2[19], r2};
      if (nd > DELAY_HI) begin
         nd_sat = DELAY_HI[DELAY_W-1:0];
      end else if (nd < DELAY_LO) begin
         nd_sat = DELAY_LO[DELAY_W-1:0];
      end else begin
         nd_sat = nd[DELAY_W-1:0];
      end
      if (hpm_ff) begin
         y_rnd = x16 - {ap_ff[AP_W-1], ap_ff} + 20'sd2;
      end else begin
         y_rnd = x16 + {ap_ff[AP_W-1], ap_ff} + 20'sd2;
      end
      y_q = y_rnd[19:2];
      if (y_q > OUT_HI) begin
         y_sat = OUT_HI[SAMPLE_W-1:0];
      end else if (y_q < OUT_LO) begin
         y_sat = OUT_LO[SAMPLE_W-1:0];
      end else begin
         y_sat = y_q[SAMPLE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         delay_mem[ch_ff] <= nd_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (finish) begin
         valid_ff[ch_ff] <= 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_filtered_ff <= y_sat;
         rsp_channel_ff <= CHANNEL_W'(ch_ff);
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.filtered = rsp_filtered_ff;
   assign rsp_chan.channel = rsp_channel_ff;

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == S_MUL1))
      else $error("accepted request did not start the multiply sequence");

   a_finish_loads: assert property (@(posedge clock) disable iff (reset)
      finish |=> (rsp_valid_ff && (state_ff == S_IDLE)))
      else $error("finished request did not load the result register");

   a_channel_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> (CW'(ch_ff) < count_eff))
      else $error("active channel beyond the channel count in use");

endmodule

FILE: src/apf_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared multiplier
// Signed coefficient by operand multiplier with a registered product, used
// twice per sample by the filter sequencer.
// ----------------------------------------------------------------------------
module apf_mul (
   input  logic                                clock,
   input  logic                                enable,
   input  logic signed [apf_pkg::COEF_W-1:0]   coef,
   input  logic signed [apf_pkg::AP_W-1:0]     operand,
   output logic signed [apf_pkg::PROD_W-1:0]   product
);
   import apf_pkg::*;

   logic signed [PROD_W-1:0] product_ff;
   logic signed [PROD_W-1:0] product_in;

   always_comb begin
      product_in = PROD_W'(coef) * PROD_W'(operand);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         product_ff <= product_in;
      end
   end

   assign product = product_ff;

endmodule

FILE: tb/sv/tb_allpass_lowpass_highpass_filter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Allpass lowpass/highpass filter core testbench
// Streams interleaved samples through the core under changing coefficient,
// mode and channel count settings. An in-bench filter model predicts every
// filtered sample and its channel. The monitor compares each response with
// the oldest prediction. Both handshakes are throttled at random.
// ----------------------------------------------------------------------------
module tb_allpass_lowpass_highpass_filter_core;
   import apf_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;
   localparam longint DELAY_HI = (longint'(1) <<< (DELAY_W - 1)) - 1;
   localparam longint DELAY_LO = -(longint'(1) <<< (DELAY_W - 1));
   localparam longint SAMPLE_HI = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
   localparam longint SAMPLE_LO = -(longint'(1) <<< (SAMPLE_W - 1));
   localparam int RANDOM_SAMPLES = 1650;

   typedef enum logic [1:0] {
      STEP_SAMPLE,
      STEP_WRITE,
      STEP_SETTLE
   } step_kind_e;

   typedef struct {
      step_kind_e                kind;
      logic [CSR_INDEX_W-1:0]    index;
      logic [CSR_DATA_W-1:0]     value;
   } schedule_step_t;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] filtered;
      logic [CHANNEL_W-1:0]       channel;
   } filter_output_t;

   logic clock;
   logic reset;

   apf_req_if req_bus ();
   apf_rsp_if rsp_bus ();
   apf_csr_if csr_bus ();

   allpass_lowpass_highpass_filter_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   schedule_step_t   sample_schedule[$];
   filter_output_t   awaited_outputs[$];
   int               error_count;

   logic signed [DELAY_W-1:0]  delay_store[MAX_CHANNELS_DEFAULT];
   int unsigned                lane_cursor;
   logic signed [COEF_W-1:0]   coef_value;
   logic                       high_pass;
   logic [COUNT_W-1:0]         lane_count;

   logic req_fired;
   logic csr_fired;
   logic rsp_fired;
   int   gap_left;
   int   send_calm;
   int   stall_left;
   int   take_calm;

   always #10 clock = ~clock;

   task automatic log_mismatch(input string msg);
      error_count++;
      if (error_count <= 40) begin
         $display("ERROR at %0t: %s", $time, msg);
      end
   endtask

   function automatic longint rounded_shift(input longint v, input int n);
      return (v + (longint'(1) <<< (n - 1))) >>> n;
   endfunction

   function automatic longint saturate(input longint v, input longint lo, input longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic filter_output_t filter_sample(input logic signed [SAMPLE_W-1:0] x);
      int unsigned lanes;
      int unsigned lane;
      longint twice_x;
      longint ap;
      longint fresh_delay;
      longint y;
      filter_output_t result;
      lanes = (lane_count == 0) ? 1 :
              ((lane_count > MAX_CHANNELS_DEFAULT) ? MAX_CHANNELS_DEFAULT : lane_count);
      lane = lane_cursor;
      if (lane >= lanes) begin
         lane = 0;
      end
      lane_cursor = (lane + 1 >= lanes) ? 0 : lane + 1;
      twice_x = 2 * longint'(x);
      ap = rounded_shift(longint'(coef_value) * longint'(x), 14) + longint'(delay_store[lane]);
      fresh_delay = saturate(twice_x - rounded_shift(longint'(coef_value) * ap, 15),
                             DELAY_LO, DELAY_HI);
      delay_store[lane] = fresh_delay[DELAY_W-1:0];
      if (high_pass) begin
         y = rounded_shift(twice_x - ap, 2);
      end else begin
         y = rounded_shift(twice_x + ap, 2);
      end
      y = saturate(y, SAMPLE_LO, SAMPLE_HI);
      result.filtered = y[SAMPLE_W-1:0];
      result.channel = lane[CHANNEL_W-1:0];
      return result;
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
         return 0;
      end else if (roll < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   task automatic push_sample(input logic [SAMPLE_W-1:0] v);
      sample_schedule.push_back('{STEP_SAMPLE, CSR_COEFFICIENT, v});
   endtask

   task automatic push_write(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] v);
      sample_schedule.push_back('{STEP_WRITE, idx, v});
   endtask

   task automatic push_settle();
      sample_schedule.push_back('{STEP_SETTLE, CSR_COEFFICIENT, '0});
   endtask

   task automatic program_registers(input logic [CSR_DATA_W-1:0] coef,
                                    input logic [CSR_DATA_W-1:0] mode_word,
                                    input logic [CSR_DATA_W-1:0] count_word);
      push_write(CSR_COEFFICIENT, coef);
      push_write(CSR_HIGH_PASS_MODE, mode_word);
      push_write(CSR_CHANNEL_COUNT, count_word);
   endtask

   // Request and configuration driver.
   always @(negedge clock) begin
      logic load_valid;
      logic write_valid;
      if (reset) begin
         req_bus.valid <= 1'b0;
         csr_bus.valid <= 1'b0;
      end else begin
         load_valid = req_bus.valid && !req_fired;
         write_valid = csr_bus.valid && !csr_fired;
         if (!load_valid && !write_valid) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (sample_schedule.size() > 0) begin
               case (sample_schedule[0].kind)
                  STEP_SAMPLE: begin
                     req_bus.sample <= sample_schedule[0].value;
                     load_valid = 1'b1;
                     void'(sample_schedule.pop_front());
                     if (send_calm > 0) begin
                        gap_left = 0;
                        send_calm--;
                     end else begin
                        gap_left = pick_gap();
                        if ($urandom_range(0, 29) == 0) begin
                           send_calm = $urandom_range(20, 80);
                        end
                     end
                  end
                  STEP_WRITE: begin
                     if (awaited_outputs.size() == 0) begin
                        csr_bus.index <= sample_schedule[0].index;
                        csr_bus.data <= sample_schedule[0].value;
                        write_valid = 1'b1;
                        void'(sample_schedule.pop_front());
                     end
                  end
                  default: begin
                     if (awaited_outputs.size() == 0) begin
                        void'(sample_schedule.pop_front());
                     end
                  end
               endcase
            end
         end
         req_bus.valid <= load_valid;
         csr_bus.valid <= write_valid;
      end
   end

   // Response backpressure.
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_fired) begin
            if (take_calm > 0) begin
               take_calm--;
            end else begin
               stall_left = pick_gap();
               if ($urandom_range(0, 29) == 0) begin
                  take_calm = $urandom_range(20, 80);
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Monitor: tracks register writes, predicts each request and checks responses.
   always @(posedge clock) begin
      filter_output_t want;
      req_fired <= !reset && req_bus.valid && req_bus.ready;
      csr_fired <= !reset && csr_bus.valid && csr_bus.ready;
      rsp_fired <= !reset && rsp_bus.valid && rsp_bus.ready;
      if (reset) begin
         foreach (delay_store[i]) begin
            delay_store[i] = '0;
         end
         lane_cursor = 0;
         coef_value = '0;
         high_pass = 1'b0;
         lane_count = 4'd1;
      end else begin
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_bus.index)
               CSR_COEFFICIENT: coef_value = csr_bus.data;
               CSR_HIGH_PASS_MODE: high_pass = csr_bus.data[0];
               CSR_CHANNEL_COUNT: lane_count = csr_bus.data[COUNT_W-1:0];
               default: ;
            endcase
         end
         if (req_bus.valid && req_bus.ready) begin
            awaited_outputs.push_back(filter_sample(req_bus.sample));
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (awaited_outputs.size() == 0) begin
               log_mismatch($sformatf("response with no request pending: filtered %0d channel %0d",
                                      rsp_bus.filtered, rsp_bus.channel));
            end else begin
               want = awaited_outputs.pop_front();
               if (rsp_bus.filtered !== want.filtered) begin
                  log_mismatch($sformatf("filtered %0d, expected %0d (channel %0d)",
                                         rsp_bus.filtered, want.filtered, want.channel));
               end
               if (rsp_bus.channel !== want.channel) begin
                  log_mismatch($sformatf("channel %0d, expected %0d",
                                         rsp_bus.channel, want.channel));
               end
            end
         end
      end
   end

   initial begin
      #20ms;
      $display("tb_allpass_lowpass_highpass_filter_core: done, errors");
      $finish;
   end

   initial begin
      int planned;
      int phase_len;
      int style;
      int roll;
      logic [CSR_DATA_W-1:0] word;
      logic [SAMPLE_W-1:0] level;
      logic [SAMPLE_W-1:0] step;
      clock = 1'b0;
      reset = 1'b1;
      error_count = 0;
      gap_left = 0;
      send_calm = 0;
      stall_left = 0;
      take_calm = 0;
      req_fired = 1'b0;
      csr_fired = 1'b0;
      rsp_fired = 1'b0;
      req_bus.valid = 1'b0;
      req_bus.sample = '0;
      csr_bus.valid = 1'b0;
      csr_bus.index = CSR_COEFFICIENT;
      csr_bus.data = '0;
      rsp_bus.ready = 1'b0;

      // Reset settings: zero coefficient, lowpass, one channel.
      push_sample(16'h7FFF);
      push_sample(16'h8000);
      push_sample(16'h0000);
      push_sample(16'hFFFF);
      push_sample(16'h0001);

      // Largest coefficient, highpass, all eight channels.
      program_registers(16'h7FFF, 16'hFFFF, 16'hFFF8);
      push_sample(16'h7FFF);
      push_sample(16'h7FFF);
      push_sample(16'h8000);
      push_sample(16'h8000);
      push_sample(16'h5555);
      push_sample(16'hAAAA);

      // Channel count lowered below the counter; coefficient of exactly -1.
      program_registers(16'h8000, 16'hFFFE, 16'h0003);
      push_sample(16'h8000);
      push_sample(16'h8000);
      push_sample(16'h7FFF);
      push_sample(16'h7FFF);

      // Channel count of zero acts as one channel.
      program_registers(16'h8001, 16'h0000, 16'hFFF0);
      push_sample(16'h7FFF);
      push_sample(16'h8000);
      push_sample(16'h1234);

      // Channel count above the maximum acts as the maximum.
      program_registers(16'h0001, 16'h0001, 16'h000F);
      push_write(CSR_UNUSED, 16'hA5A5);
      push_sample(16'hFFFF);
      push_sample(16'h7FFF);
      push_sample(16'h8000);
      push_sample(16'h0000);

      planned = 0;
      level = '0;
      while (planned < RANDOM_SAMPLES) begin
         if ($urandom_range(0, 3) != 0) begin
            roll = $urandom_range(0, 9);
            case (roll)
               0: word = 16'h7FFF;
               1: word = 16'h8001;
               2: word = 16'h8000;
               3: word = 16'h0000;
               4: word = ($urandom_range(0, 1) != 0) ? 16'h0001 : 16'hFFFF;
               default: word = 16'($urandom);
            endcase
            push_write(CSR_COEFFICIENT, word);
         end
         if ($urandom_range(0, 3) != 0) begin
            push_write(CSR_HIGH_PASS_MODE, 16'($urandom));
         end
         if ($urandom_range(0, 3) != 0) begin
            word = 16'($urandom);
            if ($urandom_range(0, 6) != 0) begin
               word[COUNT_W-1:0] = 4'($urandom_range(1, MAX_CHANNELS_DEFAULT));
            end
            push_write(CSR_CHANNEL_COUNT, word);
         end
         if ($urandom_range(0, 19) == 0) begin
            push_write(CSR_UNUSED, 16'($urandom));
         end
         phase_len = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 150) : $urandom_range(15, 60);
         style = $urandom_range(0, 3);
         step = 16'($urandom_range(1, 2048));
         for (int k = 0; k < phase_len; k++) begin
            case (style)
               0: level = 16'($urandom);
               1: begin
                  roll = $urandom_range(0, 6);
                  case (roll)
                     0: level = 16'h7FFF;
                     1: level = 16'h8000;
                     2: level = 16'h7FFE;
                     3: level = 16'h8001;
                     4: level = 16'hFFFF;
                     default: level = 16'($urandom);
                  endcase
               end
               2: begin
                  level = level + step;
                  if ($urandom_range(0, 15) == 0) begin
                     step = -step;
                  end
               end
               default: begin
                  if ($urandom_range(0, 9) == 0) begin
                     level = 16'($urandom);
                  end
               end
            endcase
            push_sample(level);
            if ($urandom_range(0, 199) == 0) begin
               push_settle();
            end
         end
         planned += phase_len;
      end

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (sample_schedule.size() != 0 || req_bus.valid || csr_bus.valid ||
             awaited_outputs.size() != 0) begin
         @(posedge clock);
      end
      repeat (10) @(posedge clock);
      if (awaited_outputs.size() != 0) begin
         log_mismatch($sformatf("%0d responses never arrived", awaited_outputs.size()));
      end
      if (error_count == 0) begin
         $display("tb_allpass_lowpass_highpass_filter_core: done, clean");
      end else begin
         $display("tb_allpass_lowpass_highpass_filter_core: done, errors");
      end
      $finish;
   end

endmodule

FILE: allpass_lowpass_highpass_filter_core.f
src/apf_pkg.sv
src/apf_req_if.sv
src/apf_rsp_if.sv
src/apf_csr_if.sv
src/apf_mul.sv
src/allpass_lowpass_highpass_filter_core.sv
tb/sv/tb_allpass_lowpass_highpass_filter_core.sv
